@@ design/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, payload types and register codes of the ray/sphere intersection
// pipeline. Values are fixed point with FRAC_BITS fraction bits, some signed.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int W_CRD = 32;                    // coordinate
    localparam int W_T   = 31;                    // distance, radius
    localparam int W_OC  = W_CRD + 1;             // origin minus center
    localparam int W_A   = 2 * W_CRD - FRAC_BITS; // D.D
    localparam int W_H   = 66 - FRAC_BITS;        // oc.D, signed
    localparam int W_HM  = W_H - 1;               // |h|
    localparam int W_CM  = 66 - FRAC_BITS;        // oc.oc
    localparam int W_C   = W_CM + 1;              // oc.oc - R*R, signed
    localparam int W_D   = 132 - 2 * FRAC_BITS;   // discriminant, even
    localparam int W_S   = W_D / 2;               // sqrt of discriminant
    localparam int W_N   = W_S + 2;               // root numerator, signed
    localparam int W_AS  = W_A + W_T - FRAC_BITS; // a scaled to quotient limit
    localparam int W_ST  = 2 * W_CRD - FRAC_BITS; // D*t step, signed
    localparam int W_V   = W_ST + 1;              // oc + step, signed
    localparam int W_VM  = W_ST;                  // |v|
    localparam int W_VV  = 2 * W_VM + 2;          // v.v, even
    localparam int W_L   = W_VV / 2;              // |v| length
    localparam int W_NQ  = FRAC_BITS + 1;         // normal magnitude
    localparam int W_NRM = 18;                    // normal component

    // product split points
    localparam int HS = (W_HM + 1) / 2;
    localparam int AS = W_A / 2;
    localparam int CS = W_CM / 2;
    localparam int VS = W_VM / 2;

    // register index
    localparam logic CFG_T_MIN = 1'b0;
    localparam logic [W_T-1:0] T_MIN_RESET = W_T'(66);

    typedef struct packed {
        logic [2:0][W_CRD-1:0] o;
        logic [2:0][W_CRD-1:0] d;
        logic [2:0][W_OC-1:0]  oc;
        logic [W_T-1:0]        lim;
    } t_ray;

    typedef struct packed {
        t_ray           ray;
        logic [W_H-1:0] h;
        logic [W_A-1:0] a;
        logic           ok;
    } t_root_pl;

    typedef struct packed {
        t_ray ray;
        logic ok;
        logic rej_n;
        logic rej_f;
    } t_div_pl;

    typedef struct packed {
        logic                  hit;
        logic [W_T-1:0]        t;
        logic [2:0][W_CRD-1:0] p;
        logic [2:0][W_VM-1:0]  vm;
        logic [2:0]            vs;
    } t_len_pl;

    typedef struct packed {
        logic                  hit;
        logic [W_T-1:0]        t;
        logic [2:0][W_CRD-1:0] p;
        logic [2:0]            vs;
        logic                  lnz;
    } t_nrm_pl;

endpackage

@@ design/ray_sphere_intersection_top.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersection_top
// Ray/sphere hit test: discriminant, nearer then farther root against the
// distance limits, hit point and unit normal, signed fixed point.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   ray, sphere, t_limit
//   out      output     o_out_valid / i_out_stall hit, t, point, normal
//   cfg      input      APB psel/penable/pwrite   t_min at address 0
//
// One ray enters per cycle unless the output is held; the depth spans the
// two square root pipes (50 and 49 stages) and the root and normal dividers
// (31 and 17 stages). Synchronous active-low reset clears the valid bits and
// sets t_min to its default. A held result stops the whole pipeline and the
// input stall follows it; nothing advances until the held result transfers.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_top
    import rsi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [W_CRD-1:0]  i_origin_x,
    input  logic signed [W_CRD-1:0]  i_origin_y,
    input  logic signed [W_CRD-1:0]  i_origin_z,
    input  logic signed [W_CRD-1:0]  i_dir_x,
    input  logic signed [W_CRD-1:0]  i_dir_y,
    input  logic signed [W_CRD-1:0]  i_dir_z,
    input  logic signed [W_CRD-1:0]  i_center_x,
    input  logic signed [W_CRD-1:0]  i_center_y,
    input  logic signed [W_CRD-1:0]  i_center_z,
    input  logic        [W_T-1:0]    i_sphere_radius,
    input  logic        [W_T-1:0]    i_t_limit,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_hit_found,
    output logic        [W_T-1:0]    o_hit_t,
    output logic signed [W_CRD-1:0]  o_point_x,
    output logic signed [W_CRD-1:0]  o_point_y,
    output logic signed [W_CRD-1:0]  o_point_z,
    output logic signed [W_NRM-1:0]  o_normal_x,
    output logic signed [W_NRM-1:0]  o_normal_y,
    output logic signed [W_NRM-1:0]  o_normal_z,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic        [2:0]        paddr,
    input  logic        [31:0]       pwdata,
    output logic        [31:0]       prdata,
    output logic                     pready
);

    logic w_en;
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // configuration
    logic [W_T-1:0] r_t_min;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_T_MIN) ? {1'b0, r_t_min} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_min <= T_MIN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_T_MIN)) begin
            r_t_min <= pwdata[W_T-1:0];
        end
    end

    // stage 1: capture, origin minus center
    t_ray           n1_ray, r1_ray;
    logic [W_T-1:0] r1_r;
    logic           r1_v;

    always_comb begin
        n1_ray.o     = {i_origin_z, i_origin_y, i_origin_x};
        n1_ray.d     = {i_dir_z, i_dir_y, i_dir_x};
        n1_ray.oc[0] = W_OC'(i_origin_x) - W_OC'(i_center_x);
        n1_ray.oc[1] = W_OC'(i_origin_y) - W_OC'(i_center_y);
        n1_ray.oc[2] = W_OC'(i_origin_z) - W_OC'(i_center_z);
        n1_ray.lim   = i_t_limit;
    end

    // stage 2: products
    logic signed [63:0] n2_dd [3];
    logic signed [64:0] n2_od [3];
    logic signed [65:0] n2_oo [3];
    logic        [61:0] n2_rr;
    logic [W_A-1:0]     r2_dd [3];
    logic [W_H-1:0]     r2_od [3];
    logic [W_CM-1:0]    r2_oo [3];
    logic [W_A-1:0]     r2_rr;
    t_ray               r2_ray;
    logic               r2_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_dd[k] = $signed(r1_ray.d[k]) * $signed(r1_ray.d[k]);
            n2_od[k] = $signed(r1_ray.oc[k]) * $signed(r1_ray.d[k]);
            n2_oo[k] = $signed(r1_ray.oc[k]) * $signed(r1_ray.oc[k]);
        end
        n2_rr = r1_r * r1_r;
    end

    // stage 3: sums
    logic [W_CM-1:0]        n3_sq;
    logic [W_A-1:0]         r3_a;
    logic signed [W_H-1:0]  r3_h;
    logic signed [W_C-1:0]  r3_c;
    t_ray                   r3_ray;
    logic                   r3_v;

    assign n3_sq = r2_oo[0] + r2_oo[1] + r2_oo[2];

    // stage 4: magnitudes
    logic [W_HM-1:0] r4_hm;
    logic [W_CM-1:0] r4_cm;
    logic            r4_cpos, r4_anz;
    logic [W_A-1:0]  r4_a;
    logic [W_H-1:0]  r4_h;
    t_ray            r4_ray;
    logic            r4_v;

    // stage 5: partial products
    logic [2*(W_HM-HS)-1:0]      r5_hhh;
    logic [W_HM-1:0]             r5_hhl;
    logic [2*HS-1:0]             r5_hll;
    logic [W_A-AS+W_CM-CS-1:0]   r5_ahch;
    logic [W_A-AS+CS-1:0]        r5_ahcl;
    logic [AS+W_CM-CS-1:0]       r5_alch;
    logic [AS+CS-1:0]            r5_alcl;
    logic                        r5_cpos, r5_anz;
    logic [W_A-1:0]              r5_a;
    logic [W_H-1:0]              r5_h;
    t_ray                        r5_ray;
    logic                        r5_v;

    // stage 6: h*h and a*|c|
    logic [W_D-1:0] r6_hh, r6_ac;
    logic           r6_cpos, r6_anz;
    logic [W_A-1:0] r6_a;
    logic [W_H-1:0] r6_h;
    t_ray           r6_ray;
    logic           r6_v;

    // stage 7: discriminant
    logic [W_D-1:0] r7_disc;
    t_root_pl       r7_pl;
    logic           r7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ray <= n1_ray;
            r1_r   <= i_sphere_radius;

            for (int k = 0; k < 3; k++) begin
                r2_dd[k] <= W_A'(n2_dd[k] >>> FRAC_BITS);
                r2_od[k] <= W_H'(n2_od[k] >>> FRAC_BITS);
                r2_oo[k] <= W_CM'(n2_oo[k] >>> FRAC_BITS);
            end
            r2_rr  <= W_A'(n2_rr >> FRAC_BITS);
            r2_ray <= r1_ray;

            r3_a   <= r2_dd[0] + r2_dd[1] + r2_dd[2];
            r3_h   <= $signed(r2_od[0]) + $signed(r2_od[1]) + $signed(r2_od[2]);
            r3_c   <= $signed(W_C'(n3_sq)) - $signed(W_C'(r2_rr));
            r3_ray <= r2_ray;

            r4_hm   <= W_HM'(r3_h[W_H-1] ? -r3_h : r3_h);
            r4_cm   <= W_CM'(r3_c[W_C-1] ? -r3_c : r3_c);
            r4_cpos <= (r3_c > 0);
            r4_anz  <= (r3_a != '0);
            r4_a    <= r3_a;
            r4_h    <= r3_h;
            r4_ray  <= r3_ray;

            r5_hhh  <= r4_hm[W_HM-1:HS] * r4_hm[W_HM-1:HS];
            r5_hhl  <= r4_hm[W_HM-1:HS] * r4_hm[HS-1:0];
            r5_hll  <= r4_hm[HS-1:0] * r4_hm[HS-1:0];
            r5_ahch <= r4_a[W_A-1:AS] * r4_cm[W_CM-1:CS];
            r5_ahcl <= r4_a[W_A-1:AS] * r4_cm[CS-1:0];
            r5_alch <= r4_a[AS-1:0] * r4_cm[W_CM-1:CS];
            r5_alcl <= r4_a[AS-1:0] * r4_cm[CS-1:0];
            r5_cpos <= r4_cpos;
            r5_anz  <= r4_anz;
            r5_a    <= r4_a;
            r5_h    <= r4_h;
            r5_ray  <= r4_ray;

            r6_hh   <= (W_D'(r5_hhh) << (2 * HS)) + (W_D'(r5_hhl) << (HS + 1))
                     + W_D'(r5_hll);
            r6_ac   <= (W_D'(r5_ahch) << (AS + CS)) + (W_D'(r5_ahcl) << AS)
                     + (W_D'(r5_alch) << CS) + W_D'(r5_alcl);
            r6_cpos <= r5_cpos;
            r6_anz  <= r5_anz;
            r6_a    <= r5_a;
            r6_h    <= r5_h;
            r6_ray  <= r5_ray;

            r7_disc   <= r6_cpos ? (r6_hh - r6_ac) : (r6_hh + r6_ac);
            r7_pl.ray <= r6_ray;
            r7_pl.h   <= r6_h;
            r7_pl.a   <= r6_a;
            r7_pl.ok  <= r6_anz && !(r6_cpos && (r6_hh < r6_ac));
        end
    end

    // square root of the discriminant
    logic                        w_sa_v;
    logic [W_S-1:0]              w_sa_s;
    logic [$bits(t_root_pl)-1:0] w_sa_raw;
    t_root_pl                    w_sa_pl;

    rsi_sqrt_pipe #(.WX(W_D), .WP($bits(t_root_pl))) u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_x     (r7_disc),
        .i_pl    (r7_pl),
        .o_valid (w_sa_v),
        .o_root  (w_sa_s),
        .o_pl    (w_sa_raw)
    );
    assign w_sa_pl = t_root_pl'(w_sa_raw);

    // stage 8: root numerators
    logic signed [W_N-1:0] n8_hx, n8_sx;
    logic signed [W_N-1:0] r8_nn, r8_nf;
    logic [W_A-1:0]        r8_a;
    t_ray                  r8_ray;
    logic                  r8_ok, r8_v;

    assign n8_hx = W_N'($signed(w_sa_pl.h));
    assign n8_sx = $signed(W_N'(w_sa_s));

    // stage 9: range checks, divider start
    logic [W_AS-1:0]              n9_alim;
    logic [W_N-2+FRAC_BITS:0]     n9_xn, n9_xf;
    logic [1:0][W_A-1:0]          r9_den, r9_rem;
    logic [1:0][W_T-1:0]          r9_bits;
    t_div_pl                      r9_pl;
    logic                         r9_v;

    assign n9_alim = {r8_a, {(W_T - FRAC_BITS){1'b0}}};
    assign n9_xn   = {r8_nn[W_N-2:0], {FRAC_BITS{1'b0}}};
    assign n9_xf   = {r8_nf[W_N-2:0], {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (w_en) begin
            r8_v <= w_sa_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_nn  <= -n8_hx - n8_sx;
            r8_nf  <= -n8_hx + n8_sx;
            r8_a   <= w_sa_pl.a;
            r8_ray <= w_sa_pl.ray;
            r8_ok  <= w_sa_pl.ok;

            r9_den[0]   <= r8_a;
            r9_den[1]   <= r8_a;
            r9_rem[0]   <= W_A'(n9_xn >> W_T);
            r9_rem[1]   <= W_A'(n9_xf >> W_T);
            r9_bits[0]  <= n9_xn[W_T-1:0];
            r9_bits[1]  <= n9_xf[W_T-1:0];
            r9_pl.ray   <= r8_ray;
            r9_pl.ok    <= r8_ok;
            r9_pl.rej_n <= r8_nn[W_N-1] || (W_AS'(r8_nn[W_N-2:0]) >= n9_alim);
            r9_pl.rej_f <= r8_nf[W_N-1] || (W_AS'(r8_nf[W_N-2:0]) >= n9_alim);
        end
    end

    // root quotients
    logic                       w_da_v;
    logic [1:0][W_T-1:0]        w_da_q;
    logic [$bits(t_div_pl)-1:0] w_da_raw;
    t_div_pl                    w_da_pl;

    rsi_div_pipe #(.LANES(2), .WD(W_A), .WQ(W_T), .WP($bits(t_div_pl))) u_div_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r9_v),
        .i_den   (r9_den),
        .i_rem   (r9_rem),
        .i_bits  (r9_bits),
        .i_pl    (r9_pl),
        .o_valid (w_da_v),
        .o_q     (w_da_q),
        .o_pl    (w_da_raw)
    );
    assign w_da_pl = t_div_pl'(w_da_raw);

    // stage 10: root select
    logic           n10_okn, n10_okf;
    logic           r10_hit;
    logic [W_T-1:0] r10_t;
    t_ray           r10_ray;
    logic           r10_v;

    assign n10_okn = !w_da_pl.rej_n && (w_da_q[0] >= r_t_min)
                     && (w_da_q[0] <= w_da_pl.ray.lim);
    assign n10_okf = !w_da_pl.rej_f && (w_da_q[1] >= r_t_min)
                     && (w_da_q[1] <= w_da_pl.ray.lim);

    // stage 11: D*t
    logic signed [63:0]     n11_dt [3];
    logic [W_ST-1:0]        r11_st [3];
    logic                   r11_hit;
    logic [W_T-1:0]         r11_t;
    t_ray                   r11_ray;
    logic                   r11_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n11_dt[k] = $signed(r10_ray.d[k]) * $signed({1'b0, r10_t});
        end
    end

    // stage 12: point and offset from center
    logic signed [W_ST:0]   n12_p [3];
    logic [2:0][W_CRD-1:0]  r12_p;
    logic signed [W_V-1:0]  r12_vv [3];
    logic                   r12_hit;
    logic [W_T-1:0]         r12_t;
    logic                   r12_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n12_p[k] = (W_ST + 1)'($signed(r11_ray.o[k])) + (W_ST + 1)'($signed(r11_st[k]));
        end
    end

    // stage 13: magnitudes
    logic [2:0][W_VM-1:0]   r13_vm;
    logic [2:0]             r13_vs;
    logic [2:0][W_CRD-1:0]  r13_p;
    logic                   r13_hit;
    logic [W_T-1:0]         r13_t;
    logic                   r13_v;

    // stage 14: partial squares
    logic [2*(W_VM-VS)-1:0] r14_hh [3];
    logic [W_VM-1:0]        r14_hl [3];
    logic [2*VS-1:0]        r14_ll [3];
    logic [2:0][W_VM-1:0]   r14_vm;
    logic [2:0]             r14_vs;
    logic [2:0][W_CRD-1:0]  r14_p;
    logic                   r14_hit;
    logic [W_T-1:0]         r14_t;
    logic                   r14_v;

    // stage 15: squares, stage 16: v.v
    logic [W_VV-1:0]        r15_sq [3];
    t_len_pl                r15_pl;
    logic                   r15_v;
    logic [W_VV-1:0]        r16_vv;
    t_len_pl                r16_pl;
    logic                   r16_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
            r14_v <= 1'b0;
            r15_v <= 1'b0;
            r16_v <= 1'b0;
        end else if (w_en) begin
            r10_v <= w_da_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
            r13_v <= r12_v;
            r14_v <= r13_v;
            r15_v <= r14_v;
            r16_v <= r15_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_hit <= w_da_pl.ok && (n10_okn || n10_okf);
            r10_t   <= n10_okn ? w_da_q[0] : w_da_q[1];
            r10_ray <= w_da_pl.ray;

            for (int k = 0; k < 3; k++) begin
                r11_st[k] <= W_ST'(n11_dt[k] >>> FRAC_BITS);
            end
            r11_hit <= r10_hit;
            r11_t   <= r10_t;
            r11_ray <= r10_ray;

            for (int k = 0; k < 3; k++) begin
                if (n12_p[k][W_ST:W_CRD-1] == '0 || n12_p[k][W_ST:W_CRD-1] == '1) begin
                    r12_p[k] <= n12_p[k][W_CRD-1:0];
                end else begin
                    r12_p[k] <= n12_p[k][W_ST] ? {1'b1, {(W_CRD - 1){1'b0}}}
                                               : {1'b0, {(W_CRD - 1){1'b1}}};
                end
                r12_vv[k] <= W_V'($signed(r11_ray.oc[k])) + W_V'($signed(r11_st[k]));
            end
            r12_hit <= r11_hit;
            r12_t   <= r11_t;

            for (int k = 0; k < 3; k++) begin
                r13_vm[k] <= W_VM'(r12_vv[k][W_V-1] ? -r12_vv[k] : r12_vv[k]);
                r13_vs[k] <= r12_vv[k][W_V-1];
            end
            r13_p   <= r12_p;
            r13_hit <= r12_hit;
            r13_t   <= r12_t;

            for (int k = 0; k < 3; k++) begin
                r14_hh[k] <= r13_vm[k][W_VM-1:VS] * r13_vm[k][W_VM-1:VS];
                r14_hl[k] <= r13_vm[k][W_VM-1:VS] * r13_vm[k][VS-1:0];
                r14_ll[k] <= r13_vm[k][VS-1:0] * r13_vm[k][VS-1:0];
            end
            r14_vm  <= r13_vm;
            r14_vs  <= r13_vs;
            r14_p   <= r13_p;
            r14_hit <= r13_hit;
            r14_t   <= r13_t;

            for (int k = 0; k < 3; k++) begin
                r15_sq[k] <= (W_VV'(r14_hh[k]) << (2 * VS)) + (W_VV'(r14_hl[k]) << (VS + 1))
                           + W_VV'(r14_ll[k]);
            end
            r15_pl.hit <= r14_hit;
            r15_pl.t   <= r14_t;
            r15_pl.p   <= r14_p;
            r15_pl.vm  <= r14_vm;
            r15_pl.vs  <= r14_vs;

            r16_vv <= r15_sq[0] + r15_sq[1] + r15_sq[2];
            r16_pl <= r15_pl;
        end
    end

    // length of the center offset
    logic                       w_sb_v;
    logic [W_L-1:0]             w_sb_len;
    logic [$bits(t_len_pl)-1:0] w_sb_raw;
    t_len_pl                    w_sb_pl;

    rsi_sqrt_pipe #(.WX(W_VV), .WP($bits(t_len_pl))) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r16_v),
        .i_x     (r16_vv),
        .i_pl    (r16_pl),
        .o_valid (w_sb_v),
        .o_root  (w_sb_len),
        .o_pl    (w_sb_raw)
    );
    assign w_sb_pl = t_len_pl'(w_sb_raw);

    // normal quotients
    logic [2:0][W_L-1:0]        n17_den, n17_rem;
    logic [2:0][W_NQ-1:0]       n17_bits;
    t_nrm_pl                    n17_pl;
    logic                       w_db_v;
    logic [2:0][W_NQ-1:0]       w_db_q;
    logic [$bits(t_nrm_pl)-1:0] w_db_raw;
    t_nrm_pl                    w_db_pl;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n17_den[k]  = w_sb_len;
            n17_rem[k]  = W_L'(w_sb_pl.vm[k] >> 1);
            n17_bits[k] = {w_sb_pl.vm[k][0], {FRAC_BITS{1'b0}}};
        end
        n17_pl.hit = w_sb_pl.hit;
        n17_pl.t   = w_sb_pl.t;
        n17_pl.p   = w_sb_pl.p;
        n17_pl.vs  = w_sb_pl.vs;
        n17_pl.lnz = (w_sb_len != '0);
    end

    rsi_div_pipe #(.LANES(3), .WD(W_L), .WQ(W_NQ), .WP($bits(t_nrm_pl))) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sb_v),
        .i_den   (n17_den),
        .i_rem   (n17_rem),
        .i_bits  (n17_bits),
        .i_pl    (n17_pl),
        .o_valid (w_db_v),
        .o_q     (w_db_q),
        .o_pl    (w_db_raw)
    );
    assign w_db_pl = t_nrm_pl'(w_db_raw);

    // output register
    logic signed [W_NRM-1:0] n_nrm [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!w_db_pl.hit || !w_db_pl.lnz) begin
                n_nrm[k] = '0;
            end else if (w_db_pl.vs[k]) begin
                n_nrm[k] = -$signed(W_NRM'(w_db_q[k]));
            end else begin
                n_nrm[k] = $signed(W_NRM'(w_db_q[k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= w_db_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit_found <= w_db_pl.hit;
            o_hit_t     <= w_db_pl.hit ? w_db_pl.t : '0;
            o_point_x   <= w_db_pl.hit ? $signed(w_db_pl.p[0]) : '0;
            o_point_y   <= w_db_pl.hit ? $signed(w_db_pl.p[1]) : '0;
            o_point_z   <= w_db_pl.hit ? $signed(w_db_pl.p[2]) : '0;
            o_normal_x  <= n_nrm[0];
            o_normal_y  <= n_nrm[1];
            o_normal_z  <= n_nrm[2];
        end
    end

endmodule

@@ design/rsi_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// rsi_sqrt_pipe
// Pipelined integer floor square root, one result bit per stage, with a
// side payload that travels alongside.
// ----------------------------------------------------------------------------
module rsi_sqrt_pipe #(
    parameter int WX = 100,
    parameter int WP = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [WX-1:0]   i_x,
    input  logic [WP-1:0]   i_pl,
    output logic            o_valid,
    output logic [WX/2-1:0] o_root,
    output logic [WP-1:0]   o_pl
);

    localparam int N  = WX / 2;
    localparam int RW = N + 3;

    logic [RW-1:0] r_rem  [N];
    logic [N-1:0]  r_root [N];
    logic [WX-1:0] r_x    [N];
    logic [WP-1:0] r_pl   [N];
    logic          r_v    [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW-1:0] w_rem;
        logic [N-1:0]  w_root;
        logic [WX-1:0] w_x;
        logic [WP-1:0] w_pl;
        logic          w_v;
        logic [RW-1:0] n_rem;
        logic [N-1:0]  n_root;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_x    = i_x;
            assign w_pl   = i_pl;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_x    = r_x[k-1];
            assign w_pl   = r_pl[k-1];
            assign w_v    = r_v[k-1];
        end

        always_comb begin
            logic [RW-1:0] cur;
            logic [RW-1:0] trial;
            cur   = {w_rem[RW-3:0], w_x[WX-1:WX-2]};
            trial = RW'({w_root, 2'b01});
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {w_root[N-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {w_root[N-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_x[k]    <= {w_x[WX-3:0], 2'b00};
                r_pl[k]   <= w_pl;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_pl    = r_pl[N-1];

endmodule

@@ design/rsi_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rsi_div_pipe
// Pipelined restoring divider, several lanes side by side, one quotient bit
// per stage. Each lane starts from a partial remainder that the caller must
// keep below its divisor (not checked), and shifts in the low dividend bits.
// ----------------------------------------------------------------------------
module rsi_div_pipe #(
    parameter int LANES = 2,
    parameter int WD    = 48,
    parameter int WQ    = 31,
    parameter int WP    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [LANES-1:0][WD-1:0]   i_den,
    input  logic [LANES-1:0][WD-1:0]   i_rem,
    input  logic [LANES-1:0][WQ-1:0]   i_bits,
    input  logic [WP-1:0]              i_pl,
    output logic                       o_valid,
    output logic [LANES-1:0][WQ-1:0]   o_q,
    output logic [WP-1:0]              o_pl
);

    logic [LANES-1:0][WD-1:0] r_den  [WQ];
    logic [LANES-1:0][WD-1:0] r_rem  [WQ];
    logic [LANES-1:0][WQ-1:0] r_bits [WQ];
    logic [LANES-1:0][WQ-1:0] r_q    [WQ];
    logic [WP-1:0]            r_pl   [WQ];
    logic                     r_v    [WQ];

    for (genvar k = 0; k < WQ; k++) begin : g_stage
        logic [LANES-1:0][WD-1:0] w_den;
        logic [LANES-1:0][WD-1:0] w_rem;
        logic [LANES-1:0][WQ-1:0] w_bits;
        logic [LANES-1:0][WQ-1:0] w_q;
        logic [WP-1:0]            w_pl;
        logic                     w_v;
        logic [LANES-1:0][WD-1:0] n_rem;
        logic [LANES-1:0][WQ-1:0] n_q;
        logic [LANES-1:0][WQ-1:0] n_bits;

        if (k == 0) begin : g_first
            assign w_den  = i_den;
            assign w_rem  = i_rem;
            assign w_bits = i_bits;
            assign w_q    = '0;
            assign w_pl   = i_pl;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_den  = r_den[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_bits = r_bits[k-1];
            assign w_q    = r_q[k-1];
            assign w_pl   = r_pl[k-1];
            assign w_v    = r_v[k-1];
        end

        always_comb begin
            logic [WD:0] cur;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                cur       = {w_rem[l], w_bits[l][WQ-1]};
                ge        = (cur >= {1'b0, w_den[l]});
                n_rem[l]  = ge ? WD'(cur - {1'b0, w_den[l]}) : WD'(cur);
                n_q[l]    = {w_q[l][WQ-2:0], ge};
                n_bits[l] = {w_bits[l][WQ-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= w_den;
                r_rem[k]  <= n_rem;
                r_bits[k] <= n_bits;
                r_q[k]    <= n_q;
                r_pl[k]   <= w_pl;
            end
        end
    end

    assign o_valid = r_v[WQ-1];
    assign o_q     = r_q[WQ-1];
    assign o_pl    = r_pl[WQ-1];

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/sphere intersection testbench
// Drives rays through the stream port, sets t_min over the register port,
// and compares each result with an exact fixed-point hit prediction.
// ----------------------------------------------------------------------------
class hit_scoreboard;
    typedef struct packed {
        logic                   hit;
        logic [30:0]            t;
        logic [31:0]            px, py, pz;
        logic [17:0]            nx, ny, nz;
    } hit_rec;

    hit_rec      pending[$];
    logic [30:0] t_min_q;
    int          errors;

    function new();
        t_min_q = 31'd66;
        errors  = 0;
    endfunction

    static function logic signed [127:0] flr(logic signed [127:0] x);
        return x >>> 16;
    endfunction

    static function logic [127:0] isqrt(logic [127:0] x);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (128'd1 << i);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    function logic [63:0] root_q(logic signed [127:0] num, logic [127:0] a);
        logic [127:0] q;
        if (num < 0) return 64'hFFFF_FFFF_FFFF_FFFF;
        q = (num << 16) / a;
        if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
        return q[63:0];
    endfunction

    function void note_ray(logic signed [2:0][31:0] o, logic signed [2:0][31:0] d,
                           logic signed [2:0][31:0] cn, logic [30:0] rad,
                           logic [30:0] lim);
        hit_rec e;
        logic signed [127:0] oc[3], dd[3], v[3], h, c, disc, s, stp, p;
        logic [127:0] a, vv, ln, q;
        logic [63:0] t, tq;
        logic got;
        e = '{default: 0};
        a = 0; h = 0; c = 0; vv = 0; got = 0; t = 0;
        for (int i = 0; i < 3; i++) begin
            dd[i] = $signed(d[i]);
            oc[i] = $signed(o[i]) - $signed(cn[i]);
            a += flr(dd[i] * dd[i]);
            h += flr(oc[i] * dd[i]);
            c += flr(oc[i] * oc[i]);
        end
        c -= flr($signed({97'd0, rad}) * $signed({97'd0, rad}));
        disc = h * h - $signed(a) * c;
        if (a != 0 && disc >= 0) begin
            s = isqrt(disc);
            tq = root_q(-h - s, a);
            if (tq <= 64'h1_0000_0000 && tq >= t_min_q && tq <= lim) begin
                got = 1; t = tq;
            end else begin
                tq = root_q(-h + s, a);
                if (tq <= 64'h1_0000_0000 && tq >= t_min_q && tq <= lim) begin
                    got = 1; t = tq;
                end
            end
        end
        if (got) begin
            e.hit = 1;
            e.t = t[30:0];
            for (int i = 0; i < 3; i++) begin
                stp = flr(dd[i] * $signed({64'd0, t}));
                p = $signed(o[i]) + stp;
                if (p > 128'sh7FFF_FFFF) p = 128'sh7FFF_FFFF;
                if (p < -128'sh8000_0000) p = -128'sh8000_0000;
                if (i == 0) e.px = p[31:0];
                else if (i == 1) e.py = p[31:0];
                else e.pz = p[31:0];
                v[i] = oc[i] + stp;
                vv += v[i] * v[i];
            end
            ln = isqrt(vv);
            if (ln != 0) begin
                for (int i = 0; i < 3; i++) begin
                    q = ((v[i] < 0 ? -v[i] : v[i]) << 16) / ln;
                    if (v[i] < 0) q = -q;
                    if (i == 0) e.nx = q[17:0];
                    else if (i == 1) e.ny = q[17:0];
                    else e.nz = q[17:0];
                end
            end
        end
        pending = {pending, e};
    endfunction

    task report(string msg);
        errors++;
        $display("%s", msg);
    endtask

    task check(hit_rec got);
        hit_rec e;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result hit=%0b t=%h", got.hit, got.t));
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            report($sformatf(
                "mismatch exp %0b %h %h %h %h %h %h %h got %0b %h %h %h %h %h %h %h",
                e.hit, e.t, e.px, e.py, e.pz, e.nx, e.ny, e.nz,
                got.hit, got.t, got.px, got.py, got.pz, got.nx, got.ny, got.nz));
        end
    endtask
endclass

module testbench
    import rsi_pkg::*;
();

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, o_in_stall, o_out_valid, i_out_stall = 0;
    logic signed [2:0][31:0] ray_o, ray_d, sph_c;
    logic [30:0] sph_r, ray_lim;
    logic o_hit_found;
    logic [W_T-1:0] o_hit_t;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    logic signed [17:0] o_normal_x, o_normal_y, o_normal_z;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    hit_scoreboard sb;
    int cycles = 0, hold_cycles = 0;
    bit long_hold = 0, all_sent = 0;
    localparam int LIMIT = 400000;

    initial begin
        ray_o = '0; ray_d = '0; sph_c = '0; sph_r = '0; ray_lim = '0;
    end

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    ray_sphere_intersection_top i_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_origin_x(ray_o[0]), .i_origin_y(ray_o[1]), .i_origin_z(ray_o[2]),
        .i_dir_x(ray_d[0]), .i_dir_y(ray_d[1]), .i_dir_z(ray_d[2]),
        .i_center_x(sph_c[0]), .i_center_y(sph_c[1]), .i_center_z(sph_c[2]),
        .i_sphere_radius(sph_r), .i_t_limit(ray_lim),
        .o_out_valid, .i_out_stall, .o_hit_found, .o_hit_t,
        .o_point_x, .o_point_y, .o_point_z, .o_normal_x, .o_normal_y, .o_normal_z,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall, one long hold
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check('{o_hit_found, o_hit_t, o_point_x, o_point_y, o_point_z,
                       o_normal_x, o_normal_y, o_normal_z});
        if (long_hold) begin
            hold_cycles <= hold_cycles + 1;
            i_out_stall <= hold_cycles < 600;
        end else if (all_sent || $urandom_range(0, 3) != 0) i_out_stall <= 0;
        else i_out_stall <= $urandom_range(0, 9) == 0 ? 1'b1 : ($urandom_range(0, 1) == 1);
    end

    task automatic reg_write(logic [30:0] val);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= {CFG_T_MIN, 2'b00}; pwdata <= {1'b0, val};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.t_min_q = val;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_crd(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            default: return $signed($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    task automatic send(logic signed [2:0][31:0] o, logic signed [2:0][31:0] d,
                        logic signed [2:0][31:0] c, logic [30:0] r, logic [30:0] l);
        ray_o <= o; ray_d <= d; sph_c <= c; sph_r <= r; ray_lim <= l;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_ray(o, d, c, r, l);
    endtask

    task automatic send_random();
        logic signed [2:0][31:0] o, d, c;
        int m;
        m = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            o[i] = rnd_crd(m); d[i] = rnd_crd(m); c[i] = rnd_crd(m);
        end
        send(o, d, c, 31'(m == 0 ? $urandom() : $urandom_range(0, 8 << 16)),
             31'($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 64 << 16)));
    endtask

    task automatic idle_gap();
        int g;
        if ($urandom_range(0, 2) != 0) return;
        g = $urandom_range(0, 15) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3);
        i_in_valid <= 0;
        repeat (g) @(posedge i_clk);
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [30:0] R_ONE = 31'h0001_0000;
    localparam logic [30:0] R_MAX = 31'h7FFF_FFFF;

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        // directed
        send('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, R_ONE, R_MAX);
        send('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 5 * ONE}, R_ONE, R_MAX);
        send('{0, 0, 0}, '{0, 0, 1}, '{0, 0, 5 * ONE}, R_ONE, R_MAX);
        send('{0, 3 * ONE, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, R_ONE, R_MAX);
        send('{0, 0, 5 * ONE}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, R_ONE, R_MAX);
        send('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, R_ONE, 31'h0002_0000);
        send('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, 31'd0, R_MAX);
        send('{0, 0, 5 * ONE}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, 31'd0, R_MAX);
        send('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
             '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
             '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}, R_MAX, R_MAX);
        send('{32'h7FFF_0000, 0, 0}, '{ONE, 0, 0}, '{0, 0, 0}, R_MAX, R_MAX);
        send('{0, 0, 0}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{-5 * ONE, 0, 0},
             R_ONE, 31'd0);
        i_in_valid <= 0;
        drain();
        reg_write(R_MAX);
        send('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, R_ONE, 31'h0006_0000);
        i_in_valid <= 0;
        drain();
        reg_write(31'd0);
        send('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, R_ONE, 31'd0);
        send('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, R_ONE, 31'h0004_0000);
        // long receiver hold while offering
        long_hold = 1;
        repeat (260) send_random();
        i_in_valid <= 0;
        long_hold = 0;
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            reg_write(ph == 0 ? 31'd66 : ph == 1 ? R_ONE : 31'($urandom()));
            repeat (260) begin
                send_random();
                idle_gap();
            end
            i_in_valid <= 0;
            drain();
        end
        all_sent = 1;
        drain();
        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ ray_sphere_intersection_top.f @@
design/rsi_pkg.sv
design/rsi_sqrt_pipe.sv
design/rsi_div_pipe.sv
design/ray_sphere_intersection_top.sv
dv/testbench.sv
